// ----- design/lbc_pkg.sv -----
// shared constants, types and the arctangent table of the beam converter
package lbc_pkg;

   // scan and iteration sizing
   localparam int BEAMS        = 64;
   localparam int CORDIC_STEPS = 16;

   // field widths
   localparam int RANGE_W    = 16;
   localparam int ANGLE_W    = 16;
   localparam int POS_W      = 24;
   localparam int POINT_W    = 25;
   localparam int BEAM_NUM_W = 6;
   localparam int MEAN_W     = 16;

   // stream and register port widths
   localparam int REQ_W      = 104;
   localparam int RSP_W      = 104;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   // internal widths
   localparam int CNT_W  = (BEAMS > 1) ? $clog2(BEAMS) : 1;
   localparam int SUM_W  = $clog2(BEAMS * 65535 + 1);
   localparam int ITER_W = $clog2(CORDIC_STEPS);
   localparam int CW     = 27;
   localparam int ZW     = 32;

   // arithmetic constants
   localparam logic [ANGLE_W-1:0] THREE_EIGHTHS_TURN = 16'h6000;
   localparam logic [ANGLE_W-1:0] QUARTER_TURN       = 16'h4000;
   localparam logic signed [31:0] INV_GAIN_Q30       = 32'sd652032874;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_ELEV_START = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ELEV_STEP  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ENABLE     = 2'd2;

   typedef struct packed {
      logic              capture;
      logic              load_elev;
      logic              load_azim;
      logic              rotate;
      logic              compensate;
      logic              out_load;
      logic [ITER_W-1:0] step;
   } lbc_cmd_type;

   // arctangent of 2^-i in units of 2^32 per turn
   function automatic logic signed [ZW-1:0] atan_turn(input logic [4:0] idx);
      logic signed [ZW-1:0] val;
      case (idx)
         5'd0:    val = 32'sh20000000;
         5'd1:    val = 32'sh12E4051D;
         5'd2:    val = 32'sh09FB385B;
         5'd3:    val = 32'sh051111D4;
         5'd4:    val = 32'sh028B0D43;
         5'd5:    val = 32'sh0145D7E1;
         5'd6:    val = 32'sh00A2F61E;
         5'd7:    val = 32'sh00517C55;
         5'd8:    val = 32'sh0028BE53;
         5'd9:    val = 32'sh00145F2E;
         5'd10:   val = 32'sh000A2F98;
         5'd11:   val = 32'sh000517CC;
         5'd12:   val = 32'sh00028BE6;
         5'd13:   val = 32'sh000145F3;
         5'd14:   val = 32'sh0000A2F9;
         5'd15:   val = 32'sh0000517C;
         5'd16:   val = 32'sh000028BE;
         5'd17:   val = 32'sh0000145F;
         5'd18:   val = 32'sh00000A2F;
         5'd19:   val = 32'sh00000517;
         5'd20:   val = 32'sh0000028B;
         5'd21:   val = 32'sh00000145;
         5'd22:   val = 32'sh000000A2;
         5'd23:   val = 32'sh00000051;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

// ----- design/lbc_ctrl.sv -----
// sequencing state machine of the beam converter
module lbc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic                   enable,
   output lbc_pkg::lbc_cmd_type    cmd
);
   import lbc_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD_V, S_ROT_V, S_COMP_V, S_LOAD_H, S_ROT_H, S_COMP_H, S_DONE
   } state_type;

   localparam logic [ITER_W-1:0] LAST_STEP = ITER_W'(CORDIC_STEPS - 1);

   state_type         state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      iter_in  = iter_ff;
      cmd      = '0;
      cmd.step = iter_ff;
      unique case (state_ff)
         S_IDLE: begin
            // disabled requests are taken and dropped
            if (req_tvalid && enable) begin
               cmd.capture = 1'b1;
               state_in    = S_LOAD_V;
            end
         end
         S_LOAD_V: begin
            cmd.load_elev = 1'b1;
            iter_in       = '0;
            state_in      = S_ROT_V;
         end
         S_ROT_V: begin
            cmd.rotate = 1'b1;
            iter_in    = iter_ff + 1'b1;
            if (iter_ff == LAST_STEP) state_in = S_COMP_V;
         end
         S_COMP_V: begin
            cmd.compensate = 1'b1;
            state_in       = S_LOAD_H;
         end
         S_LOAD_H: begin
            cmd.load_azim = 1'b1;
            iter_in       = '0;
            state_in      = S_ROT_H;
         end
         S_ROT_H: begin
            cmd.rotate = 1'b1;
            iter_in    = iter_ff + 1'b1;
            if (iter_ff == LAST_STEP) state_in = S_COMP_H;
         end
         S_COMP_H: begin
            cmd.compensate = 1'b1;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load)     rsp_valid_in = 1'b1;
      else if (rsp_tready)  rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ----- design/lbc_dp.sv -----
// datapath: beam bookkeeping, shared cordic rotator, scan mean, result register
module lbc_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  lbc_pkg::lbc_cmd_type                cmd,
   input  logic [lbc_pkg::ANGLE_W-1:0]         elev_start,
   input  logic [lbc_pkg::ANGLE_W-1:0]         elev_step,
   input  logic [lbc_pkg::RANGE_W-1:0]         range_mm,
   input  logic [lbc_pkg::ANGLE_W-1:0]         azimuth,
   input  logic signed [lbc_pkg::POS_W-1:0]    pos_x,
   input  logic signed [lbc_pkg::POS_W-1:0]    pos_y,
   input  logic signed [lbc_pkg::POS_W-1:0]    pos_z,
   output logic [lbc_pkg::POINT_W-1:0]         point_x,
   output logic [lbc_pkg::POINT_W-1:0]         point_y,
   output logic [lbc_pkg::POINT_W-1:0]         point_z,
   output logic [lbc_pkg::BEAM_NUM_W-1:0]      beam_number,
   output logic                                last_beam,
   output logic [lbc_pkg::MEAN_W-1:0]          mean_range
);
   import lbc_pkg::*;

   localparam logic signed [CW+31:0] CMP_HALF = (CW+32)'(64'sd1 <<< 29);

   // scan bookkeeping
   logic [CNT_W-1:0]    cnt_ff;
   logic [SUM_W-1:0]    sum_ff;
   logic [SUM_W-1:0]    sum_next;
   logic                is_last;
   logic [CNT_W+15:0]   prod_full;

   // captured beam
   logic [RANGE_W-1:0]       d_ff;
   logic [ANGLE_W-1:0]       h_ff;
   logic signed [POS_W-1:0]  px_ff, py_ff, pz_ff;
   logic [ANGLE_W-1:0]       prod_ff;
   logic [BEAM_NUM_W-1:0]    bnum_ff;
   logic                     last_ff;
   logic [MEAN_W-1:0]        mean_ff;

   // rotator
   logic signed [CW-1:0] x_ff, y_ff, cos_ff;
   logic signed [ZW-1:0] z_ff;
   logic signed [CW-1:0] x_in, y_in;
   logic signed [ZW-1:0] z_in;
   logic [ANGLE_W-1:0]   angle_v, ang_sel, ang_q, ang_f;
   logic                 fold;
   logic signed [CW-1:0] src, dx, dy;
   logic signed [ZW-1:0] at;
   logic signed [CW+31:0] mul_x, mul_y, mr_x, mr_y;

   // result rounding
   logic signed [CW-1:0] rnd_x, rnd_y, rnd_z, sum_x, sum_y, dif_z;

   // result register
   logic [POINT_W-1:0]    pnt_x_ff, pnt_y_ff, pnt_z_ff;
   logic [BEAM_NUM_W-1:0] bnum_out_ff;
   logic                  last_out_ff;
   logic [MEAN_W-1:0]     mean_out_ff;

   assign prod_full = cnt_ff * elev_step;
   assign is_last   = (cnt_ff >= CNT_W'(BEAMS - 1));
   assign sum_next  = sum_ff + SUM_W'(range_mm);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sum_ff <= '0;
      end else if (cmd.capture) begin
         if (is_last) begin
            cnt_ff <= '0;
            sum_ff <= '0;
         end else begin
            cnt_ff <= cnt_ff + 1'b1;
            sum_ff <= sum_next;
         end
      end
   end

   // mean of the scan including this beam, beam count is a power of two
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         d_ff    <= range_mm;
         h_ff    <= azimuth;
         px_ff   <= pos_x;
         py_ff   <= pos_y;
         pz_ff   <= pos_z;
         prod_ff <= prod_full[ANGLE_W-1:0];
         bnum_ff <= BEAM_NUM_W'(cnt_ff);
         last_ff <= is_last;
         mean_ff <= MEAN_W'(sum_next / BEAMS);
      end
   end

   // rotator: load with quadrant fold, iterate, scale by 1/K
   always_comb begin
      angle_v = THREE_EIGHTHS_TURN - elev_start - prod_ff;
      ang_sel = cmd.load_elev ? angle_v : h_ff;
      ang_q   = ang_sel + QUARTER_TURN;
      fold    = ang_q[ANGLE_W-1];
      ang_f   = ang_sel ^ {fold, {(ANGLE_W-1){1'b0}}};
      src     = cmd.load_elev ? $signed({{(CW-RANGE_W-8){1'b0}}, d_ff, 8'h00}) : y_ff;
      dx      = y_ff >>> cmd.step;
      dy      = x_ff >>> cmd.step;
      at      = atan_turn(5'(cmd.step));
      mul_x   = x_ff * INV_GAIN_Q30;
      mul_y   = y_ff * INV_GAIN_Q30;
      mr_x    = (mul_x + CMP_HALF) >>> 30;
      mr_y    = (mul_y + CMP_HALF) >>> 30;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      if (cmd.load_elev || cmd.load_azim) begin
         x_in = fold ? -src : src;
         y_in = '0;
         z_in = $signed({ang_f, 16'h0000});
      end else if (cmd.rotate) begin
         if (!z_ff[ZW-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - at;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + at;
         end
      end else if (cmd.compensate) begin
         x_in = mr_x[CW-1:0];
         y_in = mr_y[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
      if (cmd.load_azim) cos_ff <= x_ff;
   end

   // round q8 to millimetres and apply the sensor position
   always_comb begin
      rnd_x = (x_ff + CW'(128)) >>> 8;
      rnd_y = (y_ff + CW'(128)) >>> 8;
      rnd_z = (cos_ff + CW'(128)) >>> 8;
      sum_x = rnd_x + {{(CW-POS_W){px_ff[POS_W-1]}}, px_ff};
      sum_y = rnd_y + {{(CW-POS_W){py_ff[POS_W-1]}}, py_ff};
      dif_z = rnd_z - {{(CW-POS_W){pz_ff[POS_W-1]}}, pz_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         pnt_x_ff    <= sum_x[POINT_W-1:0];
         pnt_y_ff    <= sum_y[POINT_W-1:0];
         pnt_z_ff    <= dif_z[POINT_W-1:0];
         bnum_out_ff <= bnum_ff;
         last_out_ff <= last_ff;
         mean_out_ff <= last_ff ? mean_ff : '0;
      end
   end

   assign point_x     = pnt_x_ff;
   assign point_y     = pnt_y_ff;
   assign point_z     = pnt_z_ff;
   assign beam_number = bnum_out_ff;
   assign last_beam   = last_out_ff;
   assign mean_range  = mean_out_ff;

endmodule

// ----- design/lidar_beam_to_cartesian.sv -----
// top level of the lidar beam to cartesian point converter
//
// usage:
//   req_ channel: one beam request per handshake (range, azimuth, sensor
//   position). the beam's elevation comes from an internal beam counter:
//   3/8 turn minus (start + index * step), binary angle of 65536 per turn.
//   rsp_ channel: one point per enabled beam, tlast marks the last beam of
//   a scan and then carries the mean range of the scan.
//   csr_ channel: register writes, always ready; write only while idle.
// timing:
//   rsp_tvalid rises once the request has passed through the single cordic
//   rotator, used for the elevation and then the azimuth rotation; a new
//   request is taken the cycle after the result is loaded, so each beam is
//   finished before the next one is taken.
// stall: the result register holds the point while rsp_tready is low; the
//   next request is already taken and worked on, and waits at the end.
// reset: beam counter, range sum, handshakes cleared; start and step go to
//   0, enable to 1. disabled beams are taken and dropped with no result.
module lidar_beam_to_cartesian (
   input  logic                             clock,
   input  logic                             reset,
   // request: range_mm[15:0], azimuth[31:16], pos_x[55:32], pos_y[79:56],
   // pos_z[103:80]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lbc_pkg::REQ_W-1:0]        req_tdata,
   // response: point_x[24:0], point_y[49:25], point_z[74:50],
   // beam_number[80:75], mean_range[96:81], zero fill[103:97]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lbc_pkg::RSP_W-1:0]        rsp_tdata,
   output logic                             rsp_tlast,
   // register writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lbc_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [lbc_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lbc_pkg::*;

   logic [ANGLE_W-1:0]      elev_start_ff, elev_step_ff;
   logic                    enable_ff;
   lbc_cmd_type             cmd;
   logic [POINT_W-1:0]      point_x, point_y, point_z;
   logic [BEAM_NUM_W-1:0]   beam_number;
   logic [MEAN_W-1:0]       mean_range;

   // register file, writes never stall
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         elev_start_ff <= '0;
         elev_step_ff  <= '0;
         enable_ff     <= 1'b1;
      end else if (csr_valid) begin
         unique case (csr_addr)
            CSR_ELEV_START: elev_start_ff <= csr_wdata[ANGLE_W-1:0];
            CSR_ELEV_STEP:  elev_step_ff  <= csr_wdata[ANGLE_W-1:0];
            CSR_ENABLE:     enable_ff     <= csr_wdata[0];
            default:        ;  // unused index, ignored
         endcase
      end
   end

   lbc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .enable     (enable_ff),
      .cmd        (cmd)
   );

   lbc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .elev_start  (elev_start_ff),
      .elev_step   (elev_step_ff),
      .range_mm    (req_tdata[15:0]),
      .azimuth     (req_tdata[31:16]),
      .pos_x       (req_tdata[55:32]),
      .pos_y       (req_tdata[79:56]),
      .pos_z       (req_tdata[103:80]),
      .point_x     (point_x),
      .point_y     (point_y),
      .point_z     (point_z),
      .beam_number (beam_number),
      .last_beam   (rsp_tlast),
      .mean_range  (mean_range)
   );

   // pack the point fields, first field lowest
   assign rsp_tdata = {7'b0, mean_range, beam_number, point_z, point_y, point_x};

endmodule

// ----- design/lbc_checker.sv -----
// port-level checks of the beam converter and their binding to the top level
module lbc_checker (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [lbc_pkg::RSP_W-1:0]        rsp_tdata,
   input  logic                             rsp_tlast
);
   import lbc_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled response changed");

   // reset leaves no result pending
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // the mean is only reported on the last beam of a scan
   a_mean_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[96:81] == '0)
      else $error("mean range set on a beam that is not last");

   // the last beam carries the final beam number
   a_last_num: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[80:75] == BEAM_NUM_W'(BEAMS - 1))
      else $error("last beam with wrong beam number");

   // a result is never produced in the cycle right after taking a request
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("response too soon after request");

endmodule

bind lidar_beam_to_cartesian lbc_checker u_lbc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
